// ===== rtl/altitude_line_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the altitude line parser
// Shared property wrappers, clocked on i_clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_LINE_PARSER_TOP_MACROS_SVH
`define ALTITUDE_LINE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define ALP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ALP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/alp_pkg.sv =====
// ----------------------------------------------------------------------------
// Altitude line parser package
// Status codes, phase encodings, result type and character helpers.
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_X_LO   = 8'h78;
    localparam logic [7:0]  CH_X_UP   = 8'h58;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CSUM   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NONNUM = 3'd3,
        ST_LONG   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        LP_LEAD = 3'b001,
        LP_DATA = 3'b010,
        LP_CSUM = 3'b100
    } t_line_phase;

    typedef enum logic [6:0] {
        HX_SKIP = 7'b000_0001,
        HX_SIGN = 7'b000_0010,
        HX_ZERO = 7'b000_0100,
        HX_X    = 7'b000_1000,
        HX_DIG  = 7'b001_0000,
        HX_DONE = 7'b010_0000,
        HX_OVF  = 7'b100_0000
    } t_hex_phase;

    // packed so that status lands in the low bits of the output tdata
    typedef struct packed {
        logic        ground_latched;
        logic [30:0] ground_elevation;
        logic [30:0] reading_value;
        t_status     line_status;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_dec(c))
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

endpackage

// ===== rtl/alp_core.sv =====
// ----------------------------------------------------------------------------
// Altitude line parser core
// Running line state, per-byte update and end-of-line result with ground latch.
// ----------------------------------------------------------------------------
module alp_core #(
    parameter int MAX_LINE_LENGTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_clear,
    input  logic             i_on_pad,
    output alp_pkg::t_result o_res
);
    import alp_pkg::*;

    localparam int LenW = $clog2(MAX_LINE_LENGTH + 1);

    t_line_phase    r_lp, n_lp;
    t_hex_phase     r_hx, n_hx, hx_eff;
    logic [7:0]     r_sum, n_sum;
    logic [30:0]    r_acc, n_acc;
    logic           r_digits, n_digits;
    logic           r_space, n_space;
    logic           r_bad, n_bad;
    logic [31:0]    r_hacc, n_hacc;
    logic           r_neg, n_neg;
    logic [LenW-1:0] r_len, n_len;
    logic           r_first, n_first;
    logic [30:0]    r_ground, n_ground;

    logic           ws, dec, nl;
    logic [4:0]     hv;
    logic [34:0]    mul;
    logic [7:0]     given;
    t_status        status;
    logic [30:0]    value;

    assign ws  = is_ws(i_byte);
    assign dec = is_dec(i_byte);
    assign nl  = (i_byte == CH_NL);
    assign hv  = hex_val(i_byte);

    // acc * 10 + digit, wide enough to see saturation
    assign mul = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {31'd0, i_byte[3:0]};

    assign given = (r_hx == HX_OVF) ? 8'hFF :
                   (r_neg ? 8'(8'd0 - r_hacc[7:0]) : r_hacc[7:0]);

    always_comb begin
        value = '0;
        priority if (r_len == LenW'(MAX_LINE_LENGTH)) begin
            status = ST_LONG;
        end else if ((r_lp == LP_CSUM) && (given != r_sum)) begin
            status = ST_CSUM;
        end else if (!r_digits && !r_bad) begin
            status = ST_EMPTY;
        end else if (r_bad) begin
            status = ST_NONNUM;
        end else begin
            status = ST_OK;
            value  = r_acc;
        end
    end

    // a skip-phase byte that is not whitespace or a sign is parsed as in sign phase
    assign hx_eff = (r_hx == HX_SKIP) ? HX_SIGN : r_hx;

    always_comb begin
        n_lp     = r_lp;
        n_hx     = r_hx;
        n_sum    = r_sum;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_space  = r_space;
        n_bad    = r_bad;
        n_hacc   = r_hacc;
        n_neg    = r_neg;
        n_len    = r_len;
        n_first  = r_first;
        n_ground = r_ground;

        if (i_clear) begin
            n_lp     = LP_LEAD;
            n_hx     = HX_SKIP;
            n_sum    = '0;
            n_acc    = '0;
            n_digits = 1'b0;
            n_space  = 1'b0;
            n_bad    = 1'b0;
            n_hacc   = '0;
            n_neg    = 1'b0;
            n_len    = '0;
            n_first  = 1'b1;
            n_ground = '0;
        end else if (i_step && nl) begin
            if ((status == ST_OK) && i_on_pad && r_first) begin
                n_ground = value;
                n_first  = 1'b0;
            end
            n_lp     = LP_LEAD;
            n_hx     = HX_SKIP;
            n_sum    = '0;
            n_acc    = '0;
            n_digits = 1'b0;
            n_space  = 1'b0;
            n_bad    = 1'b0;
            n_hacc   = '0;
            n_neg    = 1'b0;
            n_len    = '0;
        end else if (i_step) begin
            if (r_len < LenW'(MAX_LINE_LENGTH))
                n_len = r_len + 1'b1;
            if ((r_lp == LP_DATA) || ((r_lp == LP_LEAD) && !ws)) begin
                if (i_byte == CH_STAR) begin
                    n_lp = LP_CSUM;
                end else begin
                    n_lp  = LP_DATA;
                    n_sum = r_sum + i_byte;
                    if (ws) begin
                        n_space = 1'b1;
                    end else if (dec) begin
                        if (r_space)
                            n_bad = 1'b1;
                        n_digits = 1'b1;
                        n_acc = (mul > {4'd0, VALUE_MAX}) ? VALUE_MAX : mul[30:0];
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end else if (r_lp == LP_CSUM) begin
                if ((r_hx == HX_SKIP) && ws) begin
                    n_hx = HX_SKIP;
                end else if ((r_hx == HX_SKIP) &&
                             ((i_byte == CH_PLUS) || (i_byte == CH_MINUS))) begin
                    n_neg = (i_byte == CH_MINUS);
                    n_hx  = HX_SIGN;
                end else begin
                    unique case (hx_eff)
                        HX_SIGN: begin
                            if (i_byte == CH_ZERO) begin
                                n_hx = HX_ZERO;
                            end else if (hv[4]) begin
                                n_hacc = {28'd0, hv[3:0]};
                                n_hx   = HX_DIG;
                            end else begin
                                n_hx = HX_DONE;
                            end
                        end
                        HX_ZERO: begin
                            if ((i_byte == CH_X_LO) || (i_byte == CH_X_UP)) begin
                                n_hx = HX_X;
                            end else if (hv[4]) begin
                                n_hacc = {28'd0, hv[3:0]};
                                n_hx   = HX_DIG;
                            end else begin
                                n_hx = HX_DONE;
                            end
                        end
                        HX_X: begin
                            if (hv[4]) begin
                                n_hacc = {28'd0, hv[3:0]};
                                n_hx   = HX_DIG;
                            end else begin
                                n_hx = HX_DONE;
                            end
                        end
                        HX_DIG: begin
                            if (!hv[4])
                                n_hx = HX_DONE;
                            else if (r_hacc[31:28] != 4'd0)
                                n_hx = HX_OVF;
                            else
                                n_hacc = {r_hacc[27:0], hv[3:0]};
                        end
                        default: n_hx = r_hx;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp     <= LP_LEAD;
            r_hx     <= HX_SKIP;
            r_sum    <= '0;
            r_acc    <= '0;
            r_digits <= 1'b0;
            r_space  <= 1'b0;
            r_bad    <= 1'b0;
            r_hacc   <= '0;
            r_neg    <= 1'b0;
            r_len    <= '0;
            r_first  <= 1'b1;
            r_ground <= '0;
        end else begin
            r_lp     <= n_lp;
            r_hx     <= n_hx;
            r_sum    <= n_sum;
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_space  <= n_space;
            r_bad    <= n_bad;
            r_hacc   <= n_hacc;
            r_neg    <= n_neg;
            r_len    <= n_len;
            r_first  <= n_first;
            r_ground <= n_ground;
        end
    end

    assign o_res.line_status      = status;
    assign o_res.reading_value    = value;
    assign o_res.ground_elevation = n_ground;
    assign o_res.ground_latched   = ~n_first;

endmodule

// ===== rtl/altitude_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// Altitude line parser top level
// Stream in received bytes, stream out one parsed result per newline.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the input stream. For every newline it presents
// one result item (status, reading, ground elevation, ground flag) on the
// output stream. The newline is held in the input register while the line-state
// update computes the result, and that result is then loaded into the output
// register, from which the result item is presented. The input register
// and the output register are separate, so a new byte is taken while a result
// waits; the input stalls only when a newline meets a full output register.
// Writing on_pad_mode (address 0) sets the mode, clears the ground latch and
// drops any partial line; write it only while the stream is idle.
// ----------------------------------------------------------------------------
module altitude_line_parser_top #(
    parameter int MAX_LINE_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [2:0] line_status, [33:3] reading_value,
                                   // [64:34] ground_elevation, [65] ground_latched
);
    import alp_pkg::*;

    logic       r_on_pad;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       cfg_wr, out_free, in_nl, proc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_on_pad} : 32'd0;

    assign out_free = !r_out_valid || m_tready;
    assign in_nl    = (r_in_byte == CH_NL);
    assign proc     = r_in_valid && (!in_nl || out_free);
    assign s_tready = !r_in_valid || proc;

    alp_core #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (proc),
        .i_byte   (r_in_byte),
        .i_clear  (cfg_wr),
        .i_on_pad (r_on_pad),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_pad <= 1'b0;
        end else if (cfg_wr) begin
            r_on_pad <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready)
            r_in_byte <= s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && in_nl) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && in_nl)
            r_out <= res;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out};

`include "altitude_line_parser_top_macros.svh"

    `ALP_ASSERT_NOW(a_err_zero_value, r_out_valid && (r_out.line_status != ST_OK), r_out.reading_value == 31'd0, "reading nonzero on error status")
    `ALP_ASSERT_NOW(a_latch_needs_pad, r_out_valid && r_out.ground_latched, r_on_pad, "ground latched outside on-pad mode")
    `ALP_ASSERT_NEXT(a_out_hold, r_out_valid && !m_tready, r_out_valid && $stable(r_out), "stalled result changed")
    `ALP_ASSERT_NOW(a_status_range, r_out_valid, (r_out.line_status == ST_OK) || (r_out.line_status == ST_CSUM) || (r_out.line_status == ST_EMPTY) || (r_out.line_status == ST_NONNUM) || (r_out.line_status == ST_LONG), "status code out of range")

endmodule
